[src/qte_pkg.sv]
// Shared types and constants for the quintic trajectory evaluator.
// No dependencies; used by qte_solver, qte_eval and quintic_trajectory_eval.
package qte_pkg;

  // Fixed point formats
  localparam int FRAC_BITS      = 16;
  localparam int COEF_FRAC_BITS = 48;

  // Field widths
  localparam int DATA_W = 32;
  localparam int TIME_W = 24;
  localparam int COEF_W = 64;

  // Working widths: solver dividend/divisor and evaluator accumulators
  localparam int DIV_W  = 192;
  localparam int EVAL_W = 224;

  // Configuration register map
  localparam int NUM_REGS = 7;
  localparam int IDX_W    = 3;
  localparam logic [IDX_W-1:0] REG_START_POS = 3'd0;
  localparam logic [IDX_W-1:0] REG_START_VEL = 3'd1;
  localparam logic [IDX_W-1:0] REG_START_ACC = 3'd2;
  localparam logic [IDX_W-1:0] REG_END_POS   = 3'd3;
  localparam logic [IDX_W-1:0] REG_END_VEL   = 3'd4;
  localparam logic [IDX_W-1:0] REG_END_ACC   = 3'd5;
  localparam logic [IDX_W-1:0] REG_DURATION  = 3'd6;

  // One second in Q.F
  localparam logic [TIME_W-1:0] DURATION_RESET = TIME_W'(1 << FRAC_BITS);

  typedef struct packed {
    logic [DATA_W-1:0] start_position;
    logic [DATA_W-1:0] start_velocity;
    logic [DATA_W-1:0] start_acceleration;
    logic [DATA_W-1:0] end_position;
    logic [DATA_W-1:0] end_velocity;
    logic [DATA_W-1:0] end_acceleration;
    logic [TIME_W-1:0] duration;
  } bounds_t;

  typedef struct packed {
    logic [COEF_W-1:0] cubic;
    logic [COEF_W-1:0] quartic;
    logic [COEF_W-1:0] quintic;
  } coefs_t;

  typedef struct packed {
    logic [DATA_W-1:0] position;
    logic [DATA_W-1:0] velocity;
    logic [DATA_W-1:0] acceleration;
    logic [DATA_W-1:0] jerk;
    logic              overflow;
  } result_t;

endpackage

[src/qte_solver.sv]
// Sequential closed-form solver for the cubic, quartic and quintic coefficients.
// Depends on qte_pkg. One 32x24 multiplier and one bit-serial restoring divider.
module qte_solver (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             go,
  input  qte_pkg::bounds_t bnd,
  output qte_pkg::coefs_t  coefs,
  output logic             busy
);

  localparam int DW    = qte_pkg::DIV_W;
  localparam int CW    = qte_pkg::COEF_W;
  localparam int F     = qte_pkg::FRAC_BITS;
  localparam int C     = qte_pkg::COEF_FRAC_BITS;
  localparam int TW    = qte_pkg::TIME_W;
  localparam int LIMBS = DW / 32;
  localparam int CNT_W = $clog2(LIMBS);
  localparam int BIT_W = $clog2(CW);

  typedef enum logic [2:0] {
    S_IDLE, S_START, S_POW, S_MUL, S_PREP, S_DIV, S_STORE
  } state_t;

  typedef enum logic [1:0] {A_POW, A_NUM1, A_NUM2} ret_t;

  state_t            state_r;
  ret_t              after_r;
  logic [1:0]        k_r;
  logic [2:0]        pe_r;
  logic [CNT_W-1:0]  cnt_r;
  logic [BIT_W-1:0]  bit_cnt_r;
  logic [DW-1:0]     pow_r, src_r, acc_r, num_r, rem_r, dsh_r;
  logic              neg_r;
  logic [CW-1:0]     q_r;
  logic [CW-1:0]     cubic_r, quartic_r, quintic_r;

  function automatic logic [DW-1:0] sx(input logic [31:0] v);
    return {{(DW-32){v[31]}}, v};
  endfunction

  // Boundary terms, sign extended
  logic [DW-1:0] x0, v0, a0, x1, v1, a1, h, vs;
  logic [DW-1:0] p_w, v_w, a_w;
  assign x0 = sx(bnd.start_position);
  assign v0 = sx(bnd.start_velocity);
  assign a0 = sx(bnd.start_acceleration);
  assign x1 = sx(bnd.end_position);
  assign v1 = sx(bnd.end_velocity);
  assign a1 = sx(bnd.end_acceleration);
  assign h  = x1 - x0;
  assign vs = v1 + v0;

  // Numerator weights for the coefficient being solved
  always_comb begin
    case (k_r)
      2'd0: begin
        p_w = (h << 4) + (h << 2);
        v_w = -((v1 << 3) + (v0 << 3) + (v0 << 2));
        a_w = a1 - a0 - (a0 << 1);
      end
      2'd1: begin
        p_w = -((h << 5) - (h << 1));
        v_w = (v1 << 4) - (v1 << 1) + (v0 << 4);
        a_w = a0 + (a0 << 1) - (a1 << 1);
      end
      2'd2: begin
        p_w = (h << 3) + (h << 2);
        v_w = -((vs << 2) + (vs << 1));
        a_w = a1 - a0;
      end
      default: begin
        p_w = '0;
        v_w = '0;
        a_w = '0;
      end
    endcase
  end

  // Limb-serial multiply by duration, most significant limb first
  logic [31+TW:0] prod;
  logic [DW-1:0]  acc_step;
  assign prod     = src_r[DW-1 -: 32] * bnd.duration;
  assign acc_step = {acc_r[DW-33:0], 32'd0} + DW'(prod);

  // Magnitude of numerator, scaled to the quotient format
  logic [DW-1:0] num_mag, num_sh;
  assign num_mag = num_r[DW-1] ? -num_r : num_r;
  always_comb begin
    case (k_r)
      2'd0:    num_sh = num_mag << C;
      2'd1:    num_sh = num_mag << (C + F);
      2'd2:    num_sh = num_mag << (C + 2 * F);
      default: num_sh = '0;
    endcase
  end

  logic          ge;
  logic [CW-1:0] q_mag, q_signed;
  assign ge       = rem_r >= dsh_r;
  assign q_mag    = q_r[CW-1] ? {1'b0, {(CW-1){1'b1}}} : q_r;
  assign q_signed = neg_r ? -q_mag : q_mag;

  // Sequencer; asserting go at any point restarts the solve
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= S_IDLE;
      cubic_r   <= '0;
      quartic_r <= '0;
      quintic_r <= '0;
    end else if (go) begin
      state_r <= S_START;
    end else begin
      case (state_r)
        S_IDLE: begin
          state_r <= S_IDLE;
        end
        S_START: begin
          if (bnd.duration == '0) begin
            cubic_r   <= '0;
            quartic_r <= '0;
            quintic_r <= '0;
            state_r   <= S_IDLE;
          end else begin
            pow_r   <= DW'(1);
            pe_r    <= 3'd0;
            k_r     <= 2'd0;
            state_r <= S_POW;
          end
        end
        S_POW: begin
          acc_r   <= '0;
          cnt_r   <= '0;
          state_r <= S_MUL;
          if (pe_r == 3'(k_r) + 3'd3) begin
            src_r   <= a_w;
            after_r <= A_NUM1;
          end else begin
            src_r   <= pow_r;
            after_r <= A_POW;
          end
        end
        S_MUL: begin
          if (cnt_r != CNT_W'(LIMBS - 1)) begin
            acc_r <= acc_step;
            src_r <= {src_r[DW-33:0], 32'd0};
            cnt_r <= cnt_r + 1'b1;
          end else begin
            case (after_r)
              A_POW: begin
                pow_r   <= acc_step;
                pe_r    <= pe_r + 3'd1;
                state_r <= S_POW;
              end
              A_NUM1: begin
                // Horner in t: (a*t + v<<F)*t + p<<2F
                src_r   <= acc_step + (v_w << F);
                acc_r   <= '0;
                cnt_r   <= '0;
                after_r <= A_NUM2;
              end
              A_NUM2: begin
                num_r   <= acc_step + (p_w << (2 * F));
                state_r <= S_PREP;
              end
              default: state_r <= S_IDLE;
            endcase
          end
        end
        S_PREP: begin
          // dividend |num|*2^s + t^k, divisor 2*t^k, first test at 2^63
          neg_r     <= num_r[DW-1];
          rem_r     <= num_sh + pow_r;
          dsh_r     <= pow_r << CW;
          q_r       <= '0;
          bit_cnt_r <= '0;
          state_r   <= S_DIV;
        end
        S_DIV: begin
          if (ge) rem_r <= rem_r - dsh_r;
          q_r       <= {q_r[CW-2:0], ge};
          dsh_r     <= dsh_r >> 1;
          bit_cnt_r <= bit_cnt_r + 1'b1;
          if (bit_cnt_r == BIT_W'(CW - 1)) state_r <= S_STORE;
        end
        S_STORE: begin
          case (k_r)
            2'd0:    cubic_r   <= q_signed;
            2'd1:    quartic_r <= q_signed;
            default: quintic_r <= q_signed;
          endcase
          if (k_r == 2'd2) begin
            state_r <= S_IDLE;
          end else begin
            k_r     <= k_r + 2'd1;
            state_r <= S_POW;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign busy          = state_r != S_IDLE;
  assign coefs.cubic   = cubic_r;
  assign coefs.quartic = quartic_r;
  assign coefs.quintic = quintic_r;

endmodule

[src/qte_eval.sv]
// Pipelined evaluator: position and its first three derivatives at time t.
// Depends on qte_pkg. Five Horner steps of two stages each, then round and saturate.
module qte_eval (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_valid,
  input  logic [qte_pkg::TIME_W-1:0] in_t,
  input  qte_pkg::bounds_t           bnd,
  input  qte_pkg::coefs_t            coefs,
  output logic                       out_valid,
  output qte_pkg::result_t           out_res
);

  localparam int SW    = qte_pkg::EVAL_W;
  localparam int NL    = SW / 32;
  localparam int TW    = qte_pkg::TIME_W;
  localparam int DW    = qte_pkg::DATA_W;
  localparam int CW    = qte_pkg::COEF_W;
  localparam int F     = qte_pkg::FRAC_BITS;
  localparam int C     = qte_pkg::COEF_FRAC_BITS;
  localparam int PPW   = 32 + TW;
  localparam int ND    = 4;
  localparam int NSTEP = 5;
  localparam int NV    = 2 * NSTEP + 1;
  localparam int NT    = 2 * NSTEP - 1;

  typedef logic [SW-1:0] sword_t;

  // Falling factorial k*(k-1)*...*(k-d+1)
  function automatic int fall(input int k, input int d);
    int r;
    r = 1;
    for (int i = 0; i < d; i++) r = r * (k - i);
    return r;
  endfunction

  // Multiply by a small constant with shifts and adds
  function automatic sword_t mul_small(input sword_t x, input int m);
    sword_t r;
    r = '0;
    for (int b = 0; b < 7; b++) begin
      if (((m >> b) & 1) == 1) r = r + (x << b);
    end
    return r;
  endfunction

  // Coefficients at Q.C, sign extended
  sword_t cw [6];
  always_comb begin
    cw[0] = {{(SW-32){bnd.start_position[31]}}, bnd.start_position} << (C - F);
    cw[1] = {{(SW-32){bnd.start_velocity[31]}}, bnd.start_velocity} << (C - F);
    cw[2] = {{(SW-32){bnd.start_acceleration[31]}}, bnd.start_acceleration} << (C - F - 1);
    cw[3] = {{(SW-CW){coefs.cubic[CW-1]}}, coefs.cubic};
    cw[4] = {{(SW-CW){coefs.quartic[CW-1]}}, coefs.quartic};
    cw[5] = {{(SW-CW){coefs.quintic[CW-1]}}, coefs.quintic};
  end

  // Term added at Horner step j of derivative d (k = 5 + d - j)
  sword_t addend [ND][NSTEP+1];
  always_comb begin
    int k;
    for (int d = 0; d < ND; d++) begin
      for (int j = 0; j <= NSTEP; j++) begin
        k = 5 + d - j;
        if (k >= d && k <= 5)
          addend[d][j] = mul_small(cw[k], fall(k, d)) << ((5 - k) * F);
        else
          addend[d][j] = '0;
      end
    end
  end

  logic          v_r   [NV];
  logic [TW-1:0] t_r   [NT];
  logic [PPW-1:0] pp_r [NSTEP][ND][NL];
  sword_t        s_r   [NSTEP][ND];
  sword_t        rnd_r [ND];
  logic          rnd_v_r;

  // Horner operand entering each step
  sword_t sprev [NSTEP][ND];
  always_comb begin
    for (int d = 0; d < ND; d++) begin
      sprev[0][d] = addend[d][0];
      for (int j = 1; j < NSTEP; j++) sprev[j][d] = s_r[j-1][d];
    end
  end

  // Sum of limb products: even and odd limbs do not overlap
  sword_t snew [NSTEP][ND];
  always_comb begin
    sword_t ev, od;
    for (int j = 0; j < NSTEP; j++) begin
      for (int d = 0; d < ND; d++) begin
        ev = '0;
        od = '0;
        for (int l = 0; l < NL; l++) begin
          if ((l % 2) == 0) ev = ev | (SW'(pp_r[j][d][l]) << (32 * l));
          else              od = od | (SW'(pp_r[j][d][l]) << (32 * l));
        end
        snew[j][d] = ev + od + addend[d][j+1];
      end
    end
  end

  // Valid bits
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int p = 0; p < NV; p++) v_r[p] <= 1'b0;
      rnd_v_r   <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      v_r[0] <= in_valid;
      for (int p = 1; p < NV; p++) v_r[p] <= v_r[p-1];
      rnd_v_r   <= v_r[NV-1];
      out_valid <= rnd_v_r;
    end
  end

  // Datapath stages
  always_ff @(posedge clk) begin
    t_r[0] <= in_t;
    for (int p = 1; p < NT; p++) t_r[p] <= t_r[p-1];
    for (int j = 0; j < NSTEP; j++) begin
      for (int d = 0; d < ND; d++) begin
        for (int l = 0; l < NL; l++)
          pp_r[j][d][l] <= sprev[j][d][32*l +: 32] * t_r[2*j];
        s_r[j][d] <= snew[j][d];
      end
    end
    for (int d = 0; d < ND; d++)
      rnd_r[d] <= s_r[NSTEP-1][d] + (SW'(1) << (C + (4 - d) * F - 1));
  end

  // Drop fraction bits and saturate
  logic [DW-1:0] res   [ND];
  logic [ND-1:0] sat;
  always_comb begin
    sword_t sr;
    for (int d = 0; d < ND; d++) begin
      sr = $signed(rnd_r[d]) >>> (C + (4 - d) * F);
      sat[d] = !((&sr[SW-1:DW-1]) || !(|sr[SW-1:DW-1]));
      if (sat[d]) res[d] = sr[SW-1] ? {1'b1, {(DW-1){1'b0}}} : {1'b0, {(DW-1){1'b1}}};
      else        res[d] = sr[DW-1:0];
    end
  end

  always_ff @(posedge clk) begin
    out_res.position     <= res[0];
    out_res.velocity     <= res[1];
    out_res.acceleration <= res[2];
    out_res.jerk         <= res[3];
    out_res.overflow     <= |sat;
  end

endmodule

[src/quintic_trajectory_eval.sv]
// Quintic trajectory evaluator: each accepted sample time yields an out_valid
// strobe; one transaction per cycle while busy is low.
// busy is high after each write to a valid register index while the solver runs the
// limb-serial products and the 64-step divider once per coefficient (with duration
// zero the coefficients are cleared instead); a write during a solve restarts it.
// Synchronous reset loads the default bounds (duration 1.0) and zero coefficients.
module quintic_trajectory_eval (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       start,
  output logic                       busy,
  input  logic [qte_pkg::TIME_W-1:0] in_sample_time,
  output logic                       out_valid,
  output logic [qte_pkg::DATA_W-1:0] out_position,
  output logic [qte_pkg::DATA_W-1:0] out_velocity,
  output logic [qte_pkg::DATA_W-1:0] out_acceleration,
  output logic [qte_pkg::DATA_W-1:0] out_jerk,
  output logic                       out_overflow,
  input  logic                       cfg_we,
  input  logic [qte_pkg::IDX_W-1:0]  cfg_index,
  input  logic [qte_pkg::DATA_W-1:0] cfg_data
);

  qte_pkg::bounds_t bnd_r;
  qte_pkg::coefs_t  coefs;
  qte_pkg::result_t res;
  logic             solve_go;
  logic             solver_busy;

  assign solve_go = cfg_we && (cfg_index < qte_pkg::IDX_W'(qte_pkg::NUM_REGS));

  // Configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bnd_r.start_position     <= '0;
      bnd_r.start_velocity     <= '0;
      bnd_r.start_acceleration <= '0;
      bnd_r.end_position       <= '0;
      bnd_r.end_velocity       <= '0;
      bnd_r.end_acceleration   <= '0;
      bnd_r.duration           <= qte_pkg::DURATION_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        qte_pkg::REG_START_POS: bnd_r.start_position     <= cfg_data;
        qte_pkg::REG_START_VEL: bnd_r.start_velocity     <= cfg_data;
        qte_pkg::REG_START_ACC: bnd_r.start_acceleration <= cfg_data;
        qte_pkg::REG_END_POS:   bnd_r.end_position       <= cfg_data;
        qte_pkg::REG_END_VEL:   bnd_r.end_velocity       <= cfg_data;
        qte_pkg::REG_END_ACC:   bnd_r.end_acceleration   <= cfg_data;
        qte_pkg::REG_DURATION:  bnd_r.duration <= cfg_data[qte_pkg::TIME_W-1:0];
        default: ;
      endcase
    end
  end

  qte_solver u_solver (
    .clk   (clk),
    .rst_n (rst_n),
    .go    (solve_go),
    .bnd   (bnd_r),
    .coefs (coefs),
    .busy  (solver_busy)
  );

  assign busy = solver_busy;

  qte_eval u_eval (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (start && !solver_busy),
    .in_t      (in_sample_time),
    .bnd       (bnd_r),
    .coefs     (coefs),
    .out_valid (out_valid),
    .out_res   (res)
  );

  assign out_position     = res.position;
  assign out_velocity     = res.velocity;
  assign out_acceleration = res.acceleration;
  assign out_jerk         = res.jerk;
  assign out_overflow     = res.overflow;

endmodule

[tb/sv/quintic_trajectory_eval_tb.sv]
// Testbench for quintic_trajectory_eval: directed and random sample times over many
// boundary settings, each result checked against an exact wide-integer trajectory predictor.
// Depends on qte_pkg and the quintic_trajectory_eval RTL.
module quintic_trajectory_eval_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int LATENCY_WAIT = 16;
  localparam int STALL_LIMIT  = 20000;
  localparam int FALL[6][4] = '{'{1, 0, 0, 0}, '{1, 1, 0, 0}, '{1, 2, 2, 0},
                                '{1, 3, 6, 6}, '{1, 4, 12, 24}, '{1, 5, 20, 60}};

  logic                         clk = 1'b0;
  logic                         rst_n = 1'b0;
  logic                         start = 1'b0;
  logic                         busy;
  logic [qte_pkg::TIME_W-1:0]   in_sample_time = '0;
  logic                         out_valid;
  logic [qte_pkg::DATA_W-1:0]   out_position, out_velocity, out_acceleration, out_jerk;
  logic                         out_overflow;
  logic                         cfg_we = 1'b0;
  logic [qte_pkg::IDX_W-1:0]    cfg_index = '0;
  logic [qte_pkg::DATA_W-1:0]   cfg_data = '0;

  always #2 clk = ~clk;

  quintic_trajectory_eval DUT (.*);

  // Mirror of the boundary registers and solved coefficients
  qte_pkg::bounds_t  bounds;
  qte_pkg::coefs_t   coefs;
  qte_pkg::result_t  pending_samples[$];
  int                mismatches = 0;
  int                stall_cycles = 0;

  function automatic logic signed [255:0] wide32(logic [31:0] v);
    logic signed [255:0] r;
    r = signed'(v);
    return r;
  endfunction

  function automatic logic signed [255:0] wide64(logic [63:0] v);
    logic signed [255:0] r;
    r = signed'(v);
    return r;
  endfunction

  // One coefficient: exact numerator, rounded quotient, clamped to 63-bit magnitude
  function automatic logic [63:0] solve_coef(logic signed [255:0] p, logic signed [255:0] v,
                                             logic signed [255:0] a, int k, int s,
                                             logic [qte_pkg::TIME_W-1:0] t);
    logic signed [255:0] num, tw;
    logic [255:0] mag, tk, q;
    logic [63:0] m;
    logic neg;
    tw = {232'b0, t};
    num = (p <<< 32) + ((v * tw) <<< 16) + a * tw * tw;
    neg = num[255];
    mag = neg ? -num : num;
    mag = mag << s;
    tk = 256'd1;
    repeat (k) tk = tk * {232'b0, t};
    q = (mag + tk) / (tk << 1);
    m = (q < (256'd1 << 63)) ? q[63:0] : 64'h7FFF_FFFF_FFFF_FFFF;
    return neg ? -m : m;
  endfunction

  function automatic void solve_trajectory();
    logic signed [255:0] x0, v0, a0, x1, v1, a1, h;
    x0 = wide32(bounds.start_position);
    v0 = wide32(bounds.start_velocity);
    a0 = wide32(bounds.start_acceleration);
    x1 = wide32(bounds.end_position);
    v1 = wide32(bounds.end_velocity);
    a1 = wide32(bounds.end_acceleration);
    h = x1 - x0;
    if (bounds.duration == '0) begin
      coefs = '0;
      return;
    end
    coefs.cubic   = solve_coef(20 * h, -(8 * v1 + 12 * v0), a1 - 3 * a0, 3,
                               qte_pkg::COEF_FRAC_BITS, bounds.duration);
    coefs.quartic = solve_coef(-30 * h, 14 * v1 + 16 * v0, 3 * a0 - 2 * a1, 4,
                               qte_pkg::COEF_FRAC_BITS + qte_pkg::FRAC_BITS,
                               bounds.duration);
    coefs.quintic = solve_coef(12 * h, -6 * (v1 + v0), a1 - a0, 5,
                               qte_pkg::COEF_FRAC_BITS + 2 * qte_pkg::FRAC_BITS,
                               bounds.duration);
  endfunction

  // Position and its three derivatives at time t, rounded and saturated to Q16.16
  function automatic qte_pkg::result_t trajectory_at(logic [qte_pkg::TIME_W-1:0] t);
    logic signed [255:0] c[6];
    logic signed [255:0] acc, term, r, tw;
    logic [qte_pkg::DATA_W-1:0] vals[4];
    qte_pkg::result_t res;
    int sh;
    tw = {232'b0, t};
    c[0] = wide32(bounds.start_position) <<< 32;
    c[1] = wide32(bounds.start_velocity) <<< 32;
    c[2] = wide32(bounds.start_acceleration) <<< 31;
    c[3] = wide64(coefs.cubic);
    c[4] = wide64(coefs.quartic);
    c[5] = wide64(coefs.quintic);
    res.overflow = 1'b0;
    for (int d = 0; d < 4; d++) begin
      acc = '0;
      for (int k = d; k < 6; k++) begin
        term = c[k] * FALL[k][d];
        for (int j = 0; j < k - d; j++) term = term * tw;
        acc = acc + (term <<< ((5 - k) * qte_pkg::FRAC_BITS));
      end
      sh = qte_pkg::COEF_FRAC_BITS + (4 - d) * qte_pkg::FRAC_BITS;
      acc = acc + (256'sd1 <<< (sh - 1));
      r = acc >>> sh;
      if (r > 256'sd2147483647) begin
        vals[d] = 32'h7FFF_FFFF;
        res.overflow = 1'b1;
      end else if (r < -256'sd2147483648) begin
        vals[d] = 32'h8000_0000;
        res.overflow = 1'b1;
      end else begin
        vals[d] = r[31:0];
      end
    end
    res.position = vals[0];
    res.velocity = vals[1];
    res.acceleration = vals[2];
    res.jerk = vals[3];
    return res;
  endfunction

  // Send one sample time; start stays high after the transaction
  task automatic send_sample(logic [qte_pkg::TIME_W-1:0] t);
    start <= 1'b1;
    in_sample_time <= t;
    do @(posedge clk); while (busy);
    pending_samples.push_back(trajectory_at(t));
  endtask

  task automatic hold_sender(int n);
    start <= 1'b0;
    repeat (n) @(posedge clk);
  endtask

  // Register write once the pipeline has drained, then wait out the solve
  task automatic write_reg(logic [qte_pkg::IDX_W-1:0] idx, logic [qte_pkg::DATA_W-1:0] data);
    start <= 1'b0;
    while (pending_samples.size() != 0) @(posedge clk);
    repeat (LATENCY_WAIT) @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    @(posedge clk);
    cfg_we <= 1'b0;
    case (idx)
      qte_pkg::REG_START_POS: bounds.start_position = data;
      qte_pkg::REG_START_VEL: bounds.start_velocity = data;
      qte_pkg::REG_START_ACC: bounds.start_acceleration = data;
      qte_pkg::REG_END_POS:   bounds.end_position = data;
      qte_pkg::REG_END_VEL:   bounds.end_velocity = data;
      qte_pkg::REG_END_ACC:   bounds.end_acceleration = data;
      qte_pkg::REG_DURATION:  bounds.duration = data[qte_pkg::TIME_W-1:0];
      default: ;
    endcase
    if (idx < qte_pkg::NUM_REGS) solve_trajectory();
    @(posedge clk);
    while (busy) @(posedge clk);
  endtask

  function automatic logic [qte_pkg::DATA_W-1:0] rand_bound();
    case ($urandom_range(0, 4))
      0: return $urandom();
      1: return qte_pkg::DATA_W'($signed($urandom_range(0, 2 ** 21)) - 2 ** 20);
      2: return qte_pkg::DATA_W'($signed($urandom_range(0, 2 ** 25)) - 2 ** 24);
      3: return ($urandom_range(0, 1) != 0) ? 32'h7FFF_FFFF : 32'h8000_0000;
      default: return '0;
    endcase
  endfunction

  function automatic logic [qte_pkg::TIME_W-1:0] rand_duration();
    case ($urandom_range(0, 5))
      0: return 24'd1;
      1: return 24'hFF_FFFF;
      2: return qte_pkg::TIME_W'($urandom_range(1, 255));
      3: return qte_pkg::TIME_W'($urandom());
      default: return qte_pkg::TIME_W'($urandom_range(16384, 4 * 65536));
    endcase
  endfunction

  function automatic logic [qte_pkg::TIME_W-1:0] rand_time();
    logic [24:0] lim;
    lim = {1'b0, bounds.duration} + bounds.duration;
    if ($urandom_range(0, 2) == 0 || lim > 25'hFF_FFFF) return qte_pkg::TIME_W'($urandom());
    return qte_pkg::TIME_W'($urandom_range(0, lim));
  endfunction

  // Result checker: every strobe must match the oldest expectation
  always @(posedge clk) begin
    qte_pkg::result_t want;
    if (rst_n && out_valid) begin
      if (pending_samples.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result at %0t", $realtime);
      end else begin
        want = pending_samples.pop_front();
        if (want.position !== out_position || want.velocity !== out_velocity ||
            want.acceleration !== out_acceleration || want.jerk !== out_jerk ||
            want.overflow !== out_overflow) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch: exp p=%h v=%h a=%h j=%h o=%b got p=%h v=%h a=%h j=%h o=%b",
                     want.position, want.velocity, want.acceleration, want.jerk,
                     want.overflow, out_position, out_velocity, out_acceleration,
                     out_jerk, out_overflow);
        end
      end
    end
  end

  // Watchdog on cycles without any transaction
  always @(posedge clk) begin
    if ((start && !busy) || out_valid || cfg_we || !rst_n) stall_cycles <= 0;
    else stall_cycles <= stall_cycles + 1;
    if (stall_cycles >= STALL_LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  // Default bounds: zero trajectory at a few times
  task automatic test_reset_defaults();
    send_sample(24'd0);
    send_sample(24'd1);
    send_sample(24'h01_0000);
    send_sample(24'hFF_FFFF);
    hold_sender(0);
  endtask

  // Extreme bounds and durations, ignored register index
  task automatic test_extremes();
    write_reg(qte_pkg::REG_END_POS, 32'h0001_0000);
    send_sample(24'd0);
    send_sample(24'h00_8000);
    send_sample(24'h01_0000);
    write_reg(qte_pkg::REG_START_POS, 32'h8000_0000);
    write_reg(qte_pkg::REG_END_POS, 32'h7FFF_FFFF);
    write_reg(qte_pkg::REG_START_VEL, 32'h7FFF_FFFF);
    write_reg(qte_pkg::REG_END_VEL, 32'h8000_0000);
    write_reg(qte_pkg::REG_START_ACC, 32'h7FFF_FFFF);
    write_reg(qte_pkg::REG_END_ACC, 32'h8000_0000);
    write_reg(qte_pkg::REG_DURATION, 32'h0000_0001);
    send_sample(24'd0);
    send_sample(24'd1);
    send_sample(24'hFF_FFFF);
    write_reg(qte_pkg::REG_DURATION, 32'hFFFF_FFFF);
    send_sample(24'd0);
    send_sample(24'h7F_FFFF);
    send_sample(24'hFF_FFFF);
    write_reg(3'd7, 32'hDEAD_BEEF);
    send_sample(24'h12_3456);
    write_reg(qte_pkg::REG_DURATION, 32'h0000_0000);
    send_sample(24'h01_0000);
    send_sample(24'hFF_FFFF);
    hold_sender(0);
  endtask

  // Random boundary settings, each with a bursty stream of sample times
  task automatic test_random_trajectories();
    int sent, burst;
    for (int phase = 0; phase < 10; phase++) begin
      for (int r = 0; r < qte_pkg::NUM_REGS; r++)
        if ($urandom_range(0, 3) != 0 || phase == 0)
          write_reg(qte_pkg::IDX_W'(r),
                    (r == qte_pkg::NUM_REGS - 1) ? {8'($urandom()), rand_duration()}
                                                 : rand_bound());
      if ($urandom_range(0, 9) == 0) write_reg(3'd7, $urandom());
      sent = 0;
      while (sent < 80) begin
        burst = $urandom_range(1, 20);
        if (burst > 80 - sent) burst = 80 - sent;
        repeat (burst) begin
          send_sample(rand_time());
          sent++;
        end
        if ($urandom_range(0, 3) != 0) hold_sender($urandom_range(1, 5));
      end
    end
    hold_sender(0);
  endtask

  initial begin
    bounds = '0;
    bounds.duration = qte_pkg::DURATION_RESET;
    solve_trajectory();
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    while (busy) @(posedge clk);
    test_reset_defaults();
    test_extremes();
    test_random_trajectories();
    while (pending_samples.size() != 0) @(posedge clk);
    repeat (LATENCY_WAIT) @(posedge clk);
    if (mismatches == 0 && pending_samples.size() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
